// ----- design/mfbr_pkg.sv -----
// Package for the MSB-first bit reader: transaction types, command codes and helpers.
// Used by every module of the block; it depends on nothing else.
package mfbr_pkg;

  // Stream word width and command queue depth defaults.
  localparam int unsigned WordBitsDef   = 64;
  localparam int unsigned QueueDepthDef = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_REFUSED   = 2'd3
  } status_e;

  // Input transaction mode.
  typedef enum logic {
    MODE_SUPPLY  = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_e;

  // Command kinds, as classified by the front end.
  typedef enum logic [1:0] {
    CMD_SUPPLY    = 2'd0,
    CMD_FETCH     = 2'd1,
    CMD_BAD_COUNT = 2'd2,
    CMD_REFUSE    = 2'd3
  } cmd_kind_e;

  // One input transaction.
  typedef struct packed {
    mode_e       mode;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic [6:0]  bit_count;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [63:0] field_value;
    status_e     status;
    logic [7:0]  bits_held;
  } out_item_t;

  // One classified command between the front and the back end.
  // For a supply, word is already masked and nbits is the held bit count;
  // for a fetch, nbits is the requested field width.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [63:0] word;
    logic [6:0]  nbits;
  } cmd_t;

  // All ones in the low n bits, n in 0..64. A shift by 64 yields zero,
  // so subtracting one gives the full mask for that case.
  function automatic logic [63:0] low_mask(input logic [6:0] n);
    return (64'd1 << n) - 64'd1;
  endfunction

endpackage

// ----- design/msb_first_bit_reader.sv -----
// MSB-first bit reader: one result per accepted transaction. With an empty queue a
// transaction passes through the command queue and then the result register before its
// result is valid; one transaction per cycle is sustained while output is not stalled.
// The rate is set by the shift-and-merge in the back end, combinational ahead of the
// result register; the command queue absorbs output stalls so input stays open while
// it has room. Reset clears the current word, the held slot and the queue.
module msb_first_bit_reader #(
  parameter int unsigned WORD_BITS   = mfbr_pkg::WordBitsDef,
  parameter int unsigned QUEUE_DEPTH = mfbr_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mfbr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mfbr_pkg::out_item_t out_item_o
);

  mfbr_pkg::cmd_t front_cmd, head_cmd;
  logic           queue_full, queue_nonempty, queue_pop;

  // Classify incoming transactions.
  mfbr_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  // Queue between front and back end.
  mfbr_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .nonempty_o (queue_nonempty),
    .head_cmd_o (head_cmd)
  );

  assign in_stall_o = queue_full;

  // Execute commands and present results.
  mfbr_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_nonempty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTH
  // The unread bit total can never exceed two stream words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.bits_held <= 8'(2 * WORD_BITS))
    else $error("bits_held exceeds two words");

  // Any non-ok result carries a zero field value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != mfbr_pkg::ST_OK) |-> out_item_o.field_value == '0)
    else $error("nonzero field value on error status");

  // The queue can only fill up while a result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");
`endif

endmodule

// ----- design/mfbr_front.sv -----
// Front end of the MSB-first bit reader: classifies input transactions into commands.
// Depends on mfbr_pkg.
module mfbr_front #(
  parameter int unsigned WORD_BITS = mfbr_pkg::WordBitsDef
) (
  input  mfbr_pkg::in_item_t item_i,
  output mfbr_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] MaxBytes = 4'(WORD_BITS / 8);

  logic [3:0] bytes_sat;
  logic [6:0] supply_bits;

  // Saturate the byte count to the stream word width.
  assign bytes_sat   = (item_i.valid_bytes > MaxBytes) ? MaxBytes : item_i.valid_bytes;
  assign supply_bits = {bytes_sat, 3'b000};

  // Decode the mode and check the stateless error cases.
  always_comb begin
    cmd_o.word  = '0;
    cmd_o.nbits = item_i.bit_count;
    unique case (item_i.mode)
      mfbr_pkg::MODE_SUPPLY: begin
        if (item_i.valid_bytes == 4'd0) begin
          cmd_o.kind = mfbr_pkg::CMD_REFUSE;
        end else begin
          cmd_o.kind  = mfbr_pkg::CMD_SUPPLY;
          cmd_o.nbits = supply_bits;
          cmd_o.word  = item_i.data_word & mfbr_pkg::low_mask(supply_bits);
        end
      end
      mfbr_pkg::MODE_REQUEST: begin
        if (item_i.bit_count == 7'd0 || item_i.bit_count > 7'd64) begin
          cmd_o.kind = mfbr_pkg::CMD_BAD_COUNT;
        end else begin
          cmd_o.kind = mfbr_pkg::CMD_FETCH;
        end
      end
      default: begin
        cmd_o.kind = mfbr_pkg::CMD_BAD_COUNT;
      end
    endcase
  end

endmodule

// ----- design/mfbr_cmd_fifo.sv -----
// Short command queue between the front and the back end of the bit reader.
// Depends on mfbr_pkg for the command type.
module mfbr_cmd_fifo #(
  parameter int unsigned DEPTH = mfbr_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mfbr_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            nonempty_o,
  output mfbr_pkg::cmd_t  head_cmd_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  mfbr_pkg::cmd_t  entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign nonempty_o = (count_q != '0);
  assign head_cmd_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; no reset needed for payload.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- design/mfbr_back.sv -----
// Back end of the bit reader: holds the current and held words, cuts fields and
// drives the result register. Depends on mfbr_pkg.
module mfbr_back #(
  parameter int unsigned WORD_BITS = mfbr_pkg::WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  mfbr_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mfbr_pkg::out_item_t out_item_o
);

  logic [WORD_BITS-1:0] cur_word_q, cur_word_d;
  logic [6:0]           cur_left_q, cur_left_d;
  logic [WORD_BITS-1:0] held_word_q, held_word_d;
  logic [6:0]           held_bits_q, held_bits_d;
  logic                 out_valid_q;
  mfbr_pkg::out_item_t  out_q, res;

  logic [63:0] cur64, held64, top, bottom;
  logic [6:0]  shift, need, rest;

  // A command executes whenever the result register is free or being drained.
  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || !out_stall_i);

  assign cur64  = 64'(cur_word_q);
  assign held64 = 64'(held_word_q);
  assign shift  = cur_left_q - cmd_i.nbits;
  assign need   = cmd_i.nbits - cur_left_q;
  assign rest   = held_bits_q - need;
  assign top    = cur64 & mfbr_pkg::low_mask(cur_left_q);
  assign bottom = (held64 >> rest) & mfbr_pkg::low_mask(need);

  // Execute one command against the word state.
  always_comb begin
    cur_word_d      = cur_word_q;
    cur_left_d      = cur_left_q;
    held_word_d     = held_word_q;
    held_bits_d     = held_bits_q;
    res.field_value = '0;
    res.status      = mfbr_pkg::ST_OK;
    unique case (cmd_i.kind)
      mfbr_pkg::CMD_SUPPLY: begin
        if (held_bits_q != 7'd0) begin
          res.status = mfbr_pkg::ST_REFUSED;
        end else begin
          held_word_d = cmd_i.word[WORD_BITS-1:0];
          held_bits_d = cmd_i.nbits;
        end
      end
      mfbr_pkg::CMD_FETCH: begin
        if (cmd_i.nbits <= cur_left_q) begin
          // Field lies wholly inside the current word.
          res.field_value = (cur64 >> shift) & mfbr_pkg::low_mask(cmd_i.nbits);
          cur_left_d      = shift;
        end else if (held_bits_q < need) begin
          res.status = mfbr_pkg::ST_UNDERFLOW;
        end else begin
          // Join the leftover bits with the top of the held word.
          res.field_value = (top << need) | bottom;
          cur_word_d      = held_word_q;
          cur_left_d      = rest;
          held_word_d     = '0;
          held_bits_d     = 7'd0;
        end
      end
      mfbr_pkg::CMD_BAD_COUNT: begin
        res.status = mfbr_pkg::ST_BAD_COUNT;
      end
      mfbr_pkg::CMD_REFUSE: begin
        res.status = mfbr_pkg::ST_REFUSED;
      end
      default: begin
        res.status = mfbr_pkg::ST_BAD_COUNT;
      end
    endcase
    res.bits_held = 8'(cur_left_d) + 8'(held_bits_d);
  end

  // Word state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_word_q  <= '0;
      cur_left_q  <= '0;
      held_word_q <= '0;
      held_bits_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        cur_word_q  <= cur_word_d;
        cur_left_q  <= cur_left_d;
        held_word_q <= held_word_d;
        held_bits_q <= held_bits_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- tb/sv/msb_first_bit_reader_tb.sv -----
// Self-checking testbench for msb_first_bit_reader: directed and random supply and
// request transactions, with a scoreboard that predicts each result in order.
// Depends on mfbr_pkg and the msb_first_bit_reader RTL.
module msb_first_bit_reader_tb;

  localparam int unsigned WordBits     = 64;
  localparam int unsigned RandomItems  = 1050;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned LongHold     = 90;
  localparam int unsigned HoldAtItem   = 400;
  localparam int unsigned PauseAtItem  = 700;

  // Tracks the reader state and the queue of results still to come.
  class bit_reader_scoreboard;
    logic [63:0]         word_now;
    int unsigned         left_now;
    logic [63:0]         slot_word;
    int unsigned         slot_bits;
    mfbr_pkg::out_item_t expected_q[$];
    int unsigned         errors;

    function new();
      word_now  = '0;
      left_now  = 0;
      slot_word = '0;
      slot_bits = 0;
      errors    = 0;
    endfunction

    static function logic [63:0] ones_below(input int unsigned n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // Work out the result of one accepted transaction and advance the state.
    function void note_input(input mfbr_pkg::in_item_t item);
      mfbr_pkg::out_item_t res;
      int unsigned         nbytes;
      int unsigned         count;
      int unsigned         need;
      int unsigned         rest;
      logic [63:0]         top;
      logic [63:0]         bottom;
      res.field_value = '0;
      res.status      = mfbr_pkg::ST_OK;
      nbytes = 32'(item.valid_bytes);
      count  = 32'(item.bit_count);
      if (item.mode == mfbr_pkg::MODE_SUPPLY) begin
        if (slot_bits != 0 || nbytes == 0) begin
          res.status = mfbr_pkg::ST_REFUSED;
        end else begin
          if (nbytes > WordBits / 8) nbytes = WordBits / 8;
          slot_bits = nbytes * 8;
          slot_word = item.data_word & ones_below(slot_bits);
        end
      end else if (count == 0 || count > 64) begin
        res.status = mfbr_pkg::ST_BAD_COUNT;
      end else if (count <= left_now) begin
        // The field lies entirely in the current word.
        left_now = left_now - count;
        res.field_value = (word_now >> left_now) & ones_below(count);
      end else begin
        need = count - left_now;
        if (slot_bits < need) begin
          res.status = mfbr_pkg::ST_UNDERFLOW;
        end else begin
          // Join the leftover bits with the top of the held word.
          rest   = slot_bits - need;
          top    = word_now & ones_below(left_now);
          bottom = (slot_word >> rest) & ones_below(need);
          res.field_value = (need >= 64) ? bottom : ((top << need) | bottom);
          word_now  = slot_word;
          left_now  = rest;
          slot_word = '0;
          slot_bits = 0;
        end
      end
      res.bits_held = 8'(left_now + slot_bits);
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(input mfbr_pkg::out_item_t got);
      mfbr_pkg::out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d held %0d", $time,
                 got.field_value, got.status, got.bits_held);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.field_value !== exp_item.field_value) begin
        $display("%0t: field_value expected %h actual %h", $time,
                 exp_item.field_value, got.field_value);
        errors++;
      end
      if (got.status !== exp_item.status) begin
        $display("%0t: status expected %0d actual %0d", $time,
                 exp_item.status, got.status);
        errors++;
      end
      if (got.bits_held !== exp_item.bits_held) begin
        $display("%0t: bits_held expected %0d actual %0d", $time,
                 exp_item.bits_held, got.bits_held);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  mfbr_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  mfbr_pkg::out_item_t out_item_o;

  bit_reader_scoreboard sb = new();
  bit          hold_output;
  int unsigned idle_cycles = 0;

  msb_first_bit_reader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // Offer one transaction and wait until it is taken.
  task automatic send_item(input mfbr_pkg::in_item_t item);
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(item);
  endtask

  // Drop valid for a random gap after a transaction.
  task automatic sender_gap();
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic mfbr_pkg::in_item_t make_item(input mfbr_pkg::mode_e mode,
                                                   input logic [63:0] word,
                                                   input logic [3:0] nbytes,
                                                   input logic [6:0] count);
    mfbr_pkg::in_item_t item;
    item.mode        = mode;
    item.data_word   = word;
    item.valid_bytes = nbytes;
    item.bit_count   = count;
    return item;
  endfunction

  // Random transaction, steered by the predicted state so most are well formed.
  function automatic mfbr_pkg::in_item_t random_item();
    mfbr_pkg::in_item_t item;
    int unsigned        r;
    int unsigned        avail;
    r     = $urandom_range(99);
    avail = sb.left_now + sb.slot_bits;
    item.data_word   = {$urandom, $urandom};
    item.valid_bytes = 4'd8;
    item.bit_count   = 7'($urandom_range(1, 64));
    if (r < 8) begin
      // Noise: any mode, any byte count, any field width.
      item.mode        = mfbr_pkg::mode_e'($urandom_range(1));
      item.valid_bytes = 4'($urandom_range(15));
      item.bit_count   = 7'($urandom_range(127));
    end else if (sb.slot_bits == 0 && (r < 80 || avail == 0)) begin
      item.mode = mfbr_pkg::MODE_SUPPLY;
      if ($urandom_range(9) == 0) item.valid_bytes = 4'($urandom_range(1, 7));
    end else begin
      item.mode = mfbr_pkg::MODE_REQUEST;
      if (avail != 0 && $urandom_range(9) != 0)
        item.bit_count = 7'($urandom_range(1, (avail > 64) ? 64 : avail));
    end
    return item;
  endfunction

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    int unsigned run;
    bit          hold_taken;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      if (hold_output && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end
      run = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      run = pick_gap();
      if (run != 0) begin
        out_stall_i <= 1'b1;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Result checking and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Reset, stimulus and end of run.
  initial begin
    mfbr_pkg::in_item_t directed_q[$];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    hold_output = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty reader, bad widths, refusals, saturation, joins.
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd1));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '1, 4'd8, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd65));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '1, 4'd15, 7'd127));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, '1, 4'd0, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, '1, 4'd8, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, 64'h0123_4567_89ab_cdef, 4'd8, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd0, 7'd64));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, 64'h0123_4567_89ab_cdef, 4'd15, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd4));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd60));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, 64'hfedc_ba98_7654_3210, 4'd8, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd3));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, 64'hffff_ffff_ffff_a5a5, 4'd2, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd64));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd13));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, '1, 4'd1, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd9));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd8));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, '0, 4'd8, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '1, 4'd8, 7'd64));
    directed_q.push_back(make_item(mfbr_pkg::MODE_SUPPLY, 64'h8000_0000_0000_0001, 4'd9, 7'd0));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd1));
    directed_q.push_back(make_item(mfbr_pkg::MODE_REQUEST, '0, 4'd8, 7'd63));
    foreach (directed_q[i]) begin
      send_item(directed_q[i]);
      sender_gap();
    end

    // Random part, with one long output hold and one full drain pause.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == HoldAtItem) hold_output = 1'b1;
      if (n == PauseAtItem) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      send_item(random_item());
      sender_gap();
    end
    in_valid_i <= 1'b0;

    // Drain the remaining results, then watch for strays.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- msb_first_bit_reader.f -----
design/mfbr_pkg.sv
design/mfbr_front.sv
design/mfbr_cmd_fifo.sv
design/mfbr_back.sv
design/msb_first_bit_reader.sv
tb/sv/msb_first_bit_reader_tb.sv
